/* sv/hashed_slot_task_mailbox_unit_macros.svh */
// Assertion macros for the hashed slot task mailbox unit.
`ifndef HASHED_SLOT_TASK_MAILBOX_UNIT_MACROS_SVH
`define HASHED_SLOT_TASK_MAILBOX_UNIT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Check that cons holds in the same cycle as ante.
`define HSMU_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// Check that cons holds in the cycle after ante.
`define HSMU_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define HSMU_ASSERT_SAME(lbl, ante, cons, msg)
`define HSMU_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

/* sv/hsm_pkg.sv */
// Shared types and constants of the hashed slot task mailbox unit.
package hsm_pkg;

	// Fixed field widths
	localparam int FUNC_BITS       = 2;
	localparam int ID_BITS         = 64;
	localparam int TASK_BITS       = 32;
	localparam int OUTCOME_BITS    = 2;
	localparam int STATUS_BITS     = 4;
	localparam int SLOT_OUT_BITS   = 4;
	localparam int OUT_HANDLE_BITS = 32;

	// Hash multiplier, low half of the id is multiplied by it
	localparam int MULT_BITS = 32;
	localparam logic [MULT_BITS-1:0] HASH_MULT = 32'd2654435769;
	localparam int HASH_MAX_BITS = 8;

	// Command queue between front and back
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
	localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);
	localparam logic [QCNT_BITS-1:0] QUEUE_FULL = QCNT_BITS'(QUEUE_DEPTH);

	localparam logic [OUTCOME_BITS-1:0] OUTCOME_TERMINATED = 2'd0;

	typedef enum logic [FUNC_BITS-1:0] {
		FUNC_SUBMIT  = 2'd0,
		FUNC_STEP    = 2'd1,
		FUNC_OUTCOME = 2'd2,
		FUNC_NONE    = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		OP_SUBMIT  = 2'd0,
		OP_BAD_ID  = 2'd1,
		OP_STEP    = 2'd2,
		OP_OUTCOME = 2'd3
	} op_t;

	typedef enum logic [STATUS_BITS-1:0] {
		STAT_STORED     = 4'd0,
		STAT_FULL       = 4'd1,
		STAT_BAD_ID     = 4'd2,
		STAT_DISPATCHED = 4'd3,
		STAT_HARVESTED  = 4'd4,
		STAT_SKIPPED    = 4'd5,
		STAT_RETIRED    = 4'd6,
		STAT_KEPT       = 4'd7,
		STAT_NO_CURRENT = 4'd8
	} status_t;

	// Classified command as it travels through the queue
	typedef struct packed {
		op_t                      op;
		logic [HASH_MAX_BITS-1:0] slot;
		logic [TASK_BITS-1:0]     handle;
		logic                     terminate;
	} cmd_t;

endpackage

/* sv/hsm_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module hsm_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write one entry, read one entry into the output register
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

/* sv/hsm_front.sv */
// Front end: decodes the transaction, checks the id and hashes it.
module hsm_front #(
	parameter int HASH_BITS = 4
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              take,
	input  logic [hsm_pkg::FUNC_BITS-1:0]     func,
	input  logic [hsm_pkg::ID_BITS-1:0]       requester_id,
	input  logic [hsm_pkg::TASK_BITS-1:0]     task_handle,
	input  logic [hsm_pkg::OUTCOME_BITS-1:0]  run_outcome,
	output logic                              pending,
	output logic                              push,
	output hsm_pkg::cmd_t                     push_cmd
);

	localparam int MB = hsm_pkg::MULT_BITS;

	hsm_pkg::op_t                    op_c;
	logic [2*MB-1:0]                 prod_c;
	logic [HASH_BITS-1:0]            cross_c;

	logic                            valid_s1;
	hsm_pkg::op_t                    op_s1;
	logic [HASH_BITS-1:0]            prod_s1;
	logic [HASH_BITS-1:0]            cross_s1;
	logic [hsm_pkg::TASK_BITS-1:0]   handle_s1;
	logic                            term_s1;

	// Classify the transaction
	always_comb begin
		unique case (hsm_pkg::func_t'(func))
			hsm_pkg::FUNC_SUBMIT: begin
				op_c = (requester_id[hsm_pkg::ID_BITS-1:1] == '0) ? hsm_pkg::OP_BAD_ID
					: hsm_pkg::OP_SUBMIT;
			end
			hsm_pkg::FUNC_STEP:    op_c = hsm_pkg::OP_STEP;
			hsm_pkg::FUNC_OUTCOME: op_c = hsm_pkg::OP_OUTCOME;
			default:               op_c = hsm_pkg::OP_STEP;
		endcase
	end

	// Split the 64-bit product: low word times multiplier, plus the carry-free cross term
	assign prod_c  = (2*MB)'(requester_id[MB-1:0]) * (2*MB)'(hsm_pkg::HASH_MULT);
	assign cross_c = HASH_BITS'(requester_id[MB +: HASH_BITS]
		* hsm_pkg::HASH_MULT[HASH_BITS-1:0]);

	// Track an accepted transaction; drop unused function codes here
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= take && (hsm_pkg::func_t'(func) != hsm_pkg::FUNC_NONE);
		end
	end

	// Hold the products and payload
	always_ff @(posedge clk) begin
		if (take) begin
			op_s1     <= op_c;
			prod_s1   <= prod_c[MB +: HASH_BITS];
			cross_s1  <= cross_c;
			handle_s1 <= task_handle;
			term_s1   <= (run_outcome == hsm_pkg::OUTCOME_TERMINATED);
		end
	end

	// Finish the hash and hand the command to the queue
	always_comb begin
		push_cmd.op        = op_s1;
		push_cmd.slot      = hsm_pkg::HASH_MAX_BITS'(HASH_BITS'(prod_s1 + cross_s1));
		push_cmd.handle    = handle_s1;
		push_cmd.terminate = term_s1;
	end

	assign push    = valid_s1;
	assign pending = valid_s1;

endmodule

/* sv/hsm_queue.sv */
// Short command queue between the front and back ends.
module hsm_queue (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            push,
	input  hsm_pkg::cmd_t                   push_cmd,
	input  logic                            pop,
	output logic                            valid,
	output hsm_pkg::cmd_t                   head,
	output logic [hsm_pkg::QCNT_BITS-1:0]   count
);

	hsm_pkg::cmd_t                    entries_q [hsm_pkg::QUEUE_DEPTH];
	logic [hsm_pkg::QPTR_BITS-1:0]    wr_q;
	logic [hsm_pkg::QPTR_BITS-1:0]    rd_q;
	logic [hsm_pkg::QCNT_BITS-1:0]    count_q;

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			count_q <= count_q + hsm_pkg::QCNT_BITS'(push) - hsm_pkg::QCNT_BITS'(pop);
		end
	end

	// Store the pushed command
	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_q] <= push_cmd;
		end
	end

	assign valid = (count_q != '0);
	assign head  = entries_q[rd_q];
	assign count = count_q;

endmodule

/* sv/hsm_back.sv */
// Back end: slot table, scan pointer, current task and result register.
module hsm_back #(
	parameter int HASH_BITS   = 4,
	parameter int HANDLE_BITS = 32
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  q_valid,
	input  hsm_pkg::cmd_t                         q_cmd,
	output logic                                  q_pop,
	output logic                                  done,
	output logic [hsm_pkg::STATUS_BITS-1:0]       status,
	output logic [hsm_pkg::SLOT_OUT_BITS-1:0]     slot_index,
	output logic [hsm_pkg::OUT_HANDLE_BITS-1:0]   handle_out
);

	localparam int TS = 2 ** HASH_BITS;

	typedef enum logic [1:0] {
		BK_EXEC = 2'b01,
		BK_HARV = 2'b10
	} state_t;

	state_t                                state_q, state_d;
	logic [TS-1:0]                         ready_q, ready_d;
	logic [HASH_BITS-1:0]                  scan_q, scan_d;
	logic                                  cur_valid_q, cur_valid_d;
	logic [HANDLE_BITS-1:0]                cur_task_q;
	logic                                  load_task;

	logic [TS-1:0]                         free_c, hi_free_c;
	logic [HASH_BITS-1:0]                  hash_c, lo_idx_c, hi_idx_c, pick_c;
	logic                                  found_c;

	logic                                  we_c;
	logic [HANDLE_BITS-1:0]                rdata;

	logic                                  done_d;
	hsm_pkg::status_t                      status_d;
	logic [HASH_BITS-1:0]                  slot_d;
	logic [HANDLE_BITS-1:0]                hout_d;

	logic                                  done_q;
	hsm_pkg::status_t                      status_q;
	logic [hsm_pkg::SLOT_OUT_BITS-1:0]     slot_q;
	logic [hsm_pkg::OUT_HANDLE_BITS-1:0]   hout_q;

	// Find the first free slot at or after the hash, wrapping to the bottom
	always_comb begin
		hash_c   = HASH_BITS'(q_cmd.slot);
		free_c   = ~ready_q;
		lo_idx_c = '0;
		hi_idx_c = '0;
		for (int i = 0; i < TS; i++) begin
			hi_free_c[i] = free_c[i] && (HASH_BITS'(i) >= hash_c);
		end
		for (int i = TS - 1; i >= 0; i--) begin
			if (free_c[i]) begin
				lo_idx_c = HASH_BITS'(i);
			end
			if (hi_free_c[i]) begin
				hi_idx_c = HASH_BITS'(i);
			end
		end
		pick_c  = (|hi_free_c) ? hi_idx_c : lo_idx_c;
		found_c = |free_c;
	end

	// Execute the head command
	always_comb begin
		state_d     = state_q;
		ready_d     = ready_q;
		scan_d      = scan_q;
		cur_valid_d = cur_valid_q;
		load_task   = 1'b0;
		q_pop       = 1'b0;
		we_c        = 1'b0;
		done_d      = 1'b0;
		status_d    = hsm_pkg::STAT_STORED;
		slot_d      = '0;
		hout_d      = '0;
		unique case (state_q)
			BK_EXEC: begin
				if (q_valid) begin
					q_pop  = 1'b1;
					done_d = 1'b1;
					unique case (q_cmd.op)
						hsm_pkg::OP_SUBMIT: begin
							if (found_c) begin
								we_c            = 1'b1;
								ready_d[pick_c] = 1'b1;
								status_d        = hsm_pkg::STAT_STORED;
								slot_d          = pick_c;
							end else begin
								status_d = hsm_pkg::STAT_FULL;
							end
						end
						hsm_pkg::OP_BAD_ID: begin
							status_d = hsm_pkg::STAT_BAD_ID;
						end
						hsm_pkg::OP_STEP: begin
							if (cur_valid_q) begin
								status_d = hsm_pkg::STAT_DISPATCHED;
								hout_d   = cur_task_q;
							end else if (ready_q[scan_q]) begin
								// wait in BK_HARV for the registered slot read
								done_d  = 1'b0;
								state_d = BK_HARV;
							end else begin
								scan_d   = scan_q + 1'b1;
								status_d = hsm_pkg::STAT_SKIPPED;
								slot_d   = scan_q;
							end
						end
						hsm_pkg::OP_OUTCOME: begin
							if (!cur_valid_q) begin
								status_d = hsm_pkg::STAT_NO_CURRENT;
							end else if (q_cmd.terminate) begin
								cur_valid_d = 1'b0;
								status_d    = hsm_pkg::STAT_RETIRED;
								hout_d      = cur_task_q;
							end else begin
								status_d = hsm_pkg::STAT_KEPT;
							end
						end
						default: begin
							status_d = hsm_pkg::STAT_STORED;
						end
					endcase
				end
			end
			BK_HARV: begin
				state_d         = BK_EXEC;
				cur_valid_d     = 1'b1;
				load_task       = 1'b1;
				ready_d[scan_q] = 1'b0;
				done_d          = 1'b1;
				status_d        = hsm_pkg::STAT_HARVESTED;
				slot_d          = scan_q;
				hout_d          = rdata;
			end
			default: begin
				state_d = BK_EXEC;
			end
		endcase
	end

	// Task handle store, read at the scan pointer every cycle
	hsm_ram #(
		.WIDTH (HANDLE_BITS),
		.DEPTH (TS)
	) u_slot_ram (
		.clk   (clk),
		.we    (we_c),
		.waddr (pick_c),
		.wdata (HANDLE_BITS'(q_cmd.handle)),
		.raddr (scan_q),
		.rdata (rdata)
	);

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_EXEC;
			ready_q     <= '0;
			scan_q      <= '0;
			cur_valid_q <= 1'b0;
			done_q      <= 1'b0;
		end else begin
			state_q     <= state_d;
			ready_q     <= ready_d;
			scan_q      <= scan_d;
			cur_valid_q <= cur_valid_d;
			done_q      <= done_d;
		end
	end

	// Current task and result payload
	always_ff @(posedge clk) begin
		if (load_task) begin
			cur_task_q <= rdata;
		end
		status_q <= status_d;
		slot_q   <= hsm_pkg::SLOT_OUT_BITS'(slot_d);
		hout_q   <= hsm_pkg::OUT_HANDLE_BITS'(hout_d);
	end

	assign done       = done_q;
	assign status     = status_q;
	assign slot_index = slot_q;
	assign handle_out = hout_q;

endmodule

/* sv/hashed_slot_task_mailbox_unit.sv */
// Top level of the hashed slot task mailbox unit.
// A transaction is taken on start while busy is low. The front end decodes it and
// hashes the requester id in one registered multiply stage, then writes a command
// into a two-entry queue; the back end executes one command per cycle against the
// slot table unless a harvest holds it. Each submit, step or outcome transaction
// produces one result, shown for one cycle with done, after the hash stage
// register, the queue and the result register; a step that harvests a slot waits
// in a harvest state for the slot memory read and delays the commands behind it,
// and function code 3 produces no result. Results come out in order and must be
// taken when shown. Sustained rate is one transaction per cycle while no harvest
// holds the back end; busy rises when the hash stage and the queue, less a command
// leaving the queue this cycle, together hold as many commands as it has entries.
`include "hashed_slot_task_mailbox_unit_macros.svh"
module hashed_slot_task_mailbox_unit #(
	parameter int HASH_BITS   = 4,
	parameter int HANDLE_BITS = 32
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	output logic                                  busy,
	input  logic [hsm_pkg::FUNC_BITS-1:0]         func,
	input  logic [hsm_pkg::ID_BITS-1:0]           requester_id,
	input  logic [hsm_pkg::TASK_BITS-1:0]         task_handle,
	input  logic [hsm_pkg::OUTCOME_BITS-1:0]      run_outcome,
	output logic                                  done,
	output logic [hsm_pkg::STATUS_BITS-1:0]       status,
	output logic [hsm_pkg::SLOT_OUT_BITS-1:0]     slot_index,
	output logic [hsm_pkg::OUT_HANDLE_BITS-1:0]   handle_out
);

	logic                               take;
	logic                               pending;
	logic                               q_push;
	hsm_pkg::cmd_t                      push_cmd;
	logic                               q_pop;
	logic                               q_valid;
	hsm_pkg::cmd_t                      q_head;
	logic [hsm_pkg::QCNT_BITS-1:0]      q_count;
	logic                               no_handle_c;

	// Hold off new transactions when the queue could overflow
	assign busy = (int'(q_count) + int'(pending) - int'(q_pop)) >= hsm_pkg::QUEUE_DEPTH;
	assign take = start && !busy;

	hsm_front #(
		.HASH_BITS (HASH_BITS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.take         (take),
		.func         (func),
		.requester_id (requester_id),
		.task_handle  (task_handle),
		.run_outcome  (run_outcome),
		.pending      (pending),
		.push         (q_push),
		.push_cmd     (push_cmd)
	);

	hsm_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_cmd (push_cmd),
		.pop      (q_pop),
		.valid    (q_valid),
		.head     (q_head),
		.count    (q_count)
	);

	hsm_back #(
		.HASH_BITS   (HASH_BITS),
		.HANDLE_BITS (HANDLE_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_valid    (q_valid),
		.q_cmd      (q_head),
		.q_pop      (q_pop),
		.done       (done),
		.status     (status),
		.slot_index (slot_index),
		.handle_out (handle_out)
	);

	// Flag result codes that carry no handle
	assign no_handle_c = (status == hsm_pkg::STAT_STORED) || (status == hsm_pkg::STAT_FULL)
		|| (status == hsm_pkg::STAT_BAD_ID) || (status == hsm_pkg::STAT_SKIPPED)
		|| (status == hsm_pkg::STAT_KEPT) || (status == hsm_pkg::STAT_NO_CURRENT);

	// Queue never overflows
	`HSMU_ASSERT_SAME(a_no_overflow, q_push && !q_pop, q_count != hsm_pkg::QUEUE_FULL, "queue overflow")
	// Pushed command is visible the next cycle
	`HSMU_ASSERT_NEXT(a_push_lands, q_push, q_count != '0, "pushed command lost")
	// Full queue with nothing leaving holds off new transactions
	`HSMU_ASSERT_SAME(a_full_busy, (q_count == hsm_pkg::QUEUE_FULL) && !q_pop, busy, "busy low")
	// Results that carry no handle show zero
	`HSMU_ASSERT_SAME(a_handle_zero, done && no_handle_c, handle_out == '0, "stray handle on result")

endmodule
